>>> rtl/core/prp_pkg.sv
// Shared types and constants of the prefix record payload parser.
package prp_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 64;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE     = 2'd0,
        ST_MATCH    = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic consume;   // accept one payload byte into the parser
        logic load_out;  // load the result register for the current index
        logic advance;   // step to the next result byte
        logic rearm;     // return the parse state to its reset value
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic final_result;  // the loaded result closes the frame
    } stat_t;

endpackage

>>> rtl/core/prp_dpath.sv
// Datapath: parse registers, prefix store, address compare and result register.
module prp_dpath #(
    parameter int ADDR_BYTES = 8,
    parameter int MAX_PREFIX = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  prp_pkg::cmd_t             cmd_i,
    output prp_pkg::stat_t            stat_o,
    input  logic [prp_pkg::BYTE_W-1:0] byte_i,
    input  logic                      cfg_we_i,
    input  logic [prp_pkg::ADDR_W-1:0] cfg_data_i,
    output logic [prp_pkg::STATUS_W-1:0] out_status_o,
    output logic [prp_pkg::BYTE_W-1:0] out_byte_o,
    output logic [prp_pkg::LEN_W-1:0]  out_len_o,
    output logic                      out_last_o
);
    import prp_pkg::*;

    localparam int PW = (MAX_PREFIX > 1) ? $clog2(MAX_PREFIX) : 1;
    localparam int AW = (ADDR_BYTES > 1) ? $clog2(ADDR_BYTES) : 1;

    typedef enum logic [1:0] {
        PH_LEN    = 2'd0,
        PH_PREFIX = 2'd1,
        PH_ID     = 2'd2,
        PH_ADDR   = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   plen_reg, plen_next;
    logic [BYTE_W-1:0]   cnt_reg, cnt_next;
    logic [BYTE_W-1:0]   id_reg, id_next;
    logic                eq_reg, eq_next;
    logic                match_reg, match_next;
    logic [BYTE_W-1:0]   mid_reg, mid_next;
    logic [BYTE_W-1:0]   k_reg, k_next;
    logic [ADDR_W-1:0]   own_reg;

    logic [BYTE_W-1:0]   mem [MAX_PREFIX];
    logic [BYTE_W-1:0]   mem_q_reg;
    logic                mem_we;

    logic [STATUS_W-1:0] out_status_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_last_reg;

    logic [BYTE_W-1:0]   cnt_inc;
    logic [AW-1:0]       own_sel;
    logic [BYTE_W-1:0]   own_byte;
    logic                too_long;
    logic [BYTE_W:0]     total;

    assign cnt_inc  = cnt_reg + 8'd1;
    assign own_sel  = AW'(ADDR_BYTES - 1) - cnt_reg[AW-1:0];
    assign own_byte = own_reg[{own_sel, 3'b000} +: BYTE_W];
    assign too_long = plen_reg > 8'(MAX_PREFIX);
    assign total    = {1'b0, plen_reg} + 9'd1;
    assign mem_we   = cmd_i.consume && !match_reg && (phase_reg == PH_PREFIX)
                      && (cnt_reg < 8'(MAX_PREFIX));

    // Parser next state
    always_comb begin
        phase_next = phase_reg;
        plen_next  = plen_reg;
        cnt_next   = cnt_reg;
        id_next    = id_reg;
        eq_next    = eq_reg;
        match_next = match_reg;
        mid_next   = mid_reg;
        k_next     = k_reg;
        if (cmd_i.rearm) begin
            phase_next = PH_LEN;
            plen_next  = '0;
            cnt_next   = '0;
            id_next    = '0;
            eq_next    = 1'b1;
            match_next = 1'b0;
            mid_next   = '0;
            k_next     = '0;
        end else if (cmd_i.advance) begin
            k_next = k_reg + 8'd1;
        end else if (cmd_i.consume && !match_reg) begin
            unique case (phase_reg)
                PH_LEN: begin
                    plen_next  = byte_i;
                    cnt_next   = '0;
                    phase_next = (byte_i == '0) ? PH_ID : PH_PREFIX;
                end
                PH_PREFIX: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= plen_reg) begin
                        cnt_next   = '0;
                        phase_next = PH_ID;
                    end
                end
                PH_ID: begin
                    id_next    = byte_i;
                    eq_next    = 1'b1;
                    cnt_next   = '0;
                    phase_next = PH_ADDR;
                end
                PH_ADDR: begin
                    eq_next  = eq_reg && (byte_i == own_byte);
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 8'(ADDR_BYTES)) begin
                        if (eq_next) begin
                            match_next = 1'b1;
                            mid_next   = id_reg;
                        end
                        cnt_next   = '0;
                        phase_next = PH_ID;
                    end
                end
                default: phase_next = PH_LEN;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEN;
            plen_reg  <= '0;
            cnt_reg   <= '0;
            id_reg    <= '0;
            eq_reg    <= 1'b1;
            match_reg <= 1'b0;
            mid_reg   <= '0;
            k_reg     <= '0;
            own_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            plen_reg  <= plen_next;
            cnt_reg   <= cnt_next;
            id_reg    <= id_next;
            eq_reg    <= eq_next;
            match_reg <= match_next;
            mid_reg   <= mid_next;
            k_reg     <= k_next;
            if (cfg_we_i) begin
                own_reg <= cfg_data_i;
            end
        end
    end

    // Prefix store with registered read at the result index
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cnt_reg[PW-1:0]] <= byte_i;
        end
        mem_q_reg <= mem[k_reg[PW-1:0]];
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd_i.load_out) begin
            priority if (too_long) begin
                out_status_reg <= ST_TOO_LONG;
                out_byte_reg   <= '0;
                out_len_reg    <= '0;
                out_last_reg   <= 1'b1;
            end else if (match_reg) begin
                out_status_reg <= ST_MATCH;
                out_byte_reg   <= (k_reg < plen_reg) ? mem_q_reg : mid_reg;
                out_len_reg    <= total[LEN_W-1:0];
                out_last_reg   <= (k_reg == plen_reg);
            end else begin
                out_status_reg <= ST_NONE;
                out_byte_reg   <= '0;
                out_len_reg    <= '0;
                out_last_reg   <= 1'b1;
            end
        end
    end

    assign stat_o.final_result = out_last_reg;
    assign out_status_o        = out_status_reg;
    assign out_byte_o          = out_byte_reg;
    assign out_len_o           = out_len_reg;
    assign out_last_o          = out_last_reg;

`ifndef SYNTHESIS
    a_loaded_nonmatch_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.load_out |=> (out_status_reg == ST_MATCH || out_last_reg))
        else $error("non-match result not marked last");
    a_match_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (match_reg && !cmd_i.rearm) |=> match_reg)
        else $error("match flag dropped inside a frame");
`endif

endmodule

>>> rtl/core/prp_ctrl.sv
// Controller: parse and emit sequencing with the stream handshakes.
module prp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tlast,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output prp_pkg::cmd_t  cmd_o,
    input  prp_pkg::stat_t stat_i
);
    import prp_pkg::*;

    typedef enum logic [1:0] {
        S_PARSE = 2'd0,
        S_FETCH = 2'd1,
        S_LOAD  = 2'd2,
        S_SEND  = 2'd3
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   take;
    logic   sent;

    assign take = (state_reg == S_PARSE) && s_tvalid && s_tready_reg;
    assign sent = (state_reg == S_SEND) && m_tready;

    assign cmd_o.consume  = take;
    assign cmd_o.load_out = (state_reg == S_LOAD);
    assign cmd_o.advance  = sent && !stat_i.final_result;
    assign cmd_o.rearm    = sent && stat_i.final_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_PARSE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_PARSE: begin
                    if (take && s_tlast) begin
                        s_tready_reg <= 1'b0;
                        state_reg    <= S_FETCH;
                    end
                end
                S_FETCH: state_reg <= S_LOAD;
                S_LOAD: begin
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_SEND;
                end
                S_SEND: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (stat_i.final_result) begin
                            s_tready_reg <= 1'b1;
                            state_reg    <= S_PARSE;
                        end else begin
                            state_reg <= S_FETCH;
                        end
                    end
                end
                default: state_reg <= S_PARSE;
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTHESIS
    a_sides_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready_reg && m_tvalid_reg))
        else $error("input and output open at once");
    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD) |=> m_tvalid_reg)
        else $error("loaded result not presented");
    a_rearm_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.rearm |=> (s_tready_reg && !m_tvalid_reg))
        else $error("input not reopened after frame end");
`endif

endmodule

>>> rtl/core/prefix_record_payload_parser_top.sv
// Top level of the prefix record payload parser.
//
// Usage:
//   s_ channel: one payload byte per transaction in s_tdata, s_tlast on the
//   final byte of the frame. Frame layout: prefix length L, L prefix bytes,
//   then records of one id byte and ADDR_BYTES link-address bytes.
//   m_ channel: results. On a match, L+1 transactions carry the prefix bytes
//   then the matched id (status match); otherwise one transaction carries
//   status "no record" or "prefix too long". m_tlast closes every frame.
//   cfg channel: writes own_address; write it only while no frame is open.
// Throughput: one payload byte per cycle while parsing. After the final byte
//   s_tready drops until the last result of the frame is taken.
// Sequencing: after the final byte is accepted and after each non-final result
//   is taken, the store read (S_FETCH) and the result register (S_LOAD) come
//   first, then m_tvalid rises; the next result is fetched only once one is taken.
// Reset: aresetn (synchronous, active low) clears the parser and own_address;
//   the prefix store is not cleared, every emitted prefix byte is rewritten
//   in its own frame first.
// Stall: a result holds on m_ while m_tready is low; input stays closed.
module prefix_record_payload_parser_top #(
    parameter int ADDR_BYTES = 8,
    parameter int MAX_PREFIX = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Payload input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] payload_byte
    input  logic        s_tlast,   // last_byte
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] addr_byte, [12:8] addr_len, [15:13] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,   // last_result
    // Configuration: own_address
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);
    import prp_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [STATUS_W-1:0] out_status;
    logic [BYTE_W-1:0]   out_byte;
    logic [LEN_W-1:0]    out_len;

    // Accept every register write; the user must see that it is only issued while idle, the block does not check
    assign cfg_ready = 1'b1;

    prp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd_o    (cmd),
        .stat_i   (stat)
    );

    prp_dpath #(
        .ADDR_BYTES (ADDR_BYTES),
        .MAX_PREFIX (MAX_PREFIX)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_i        (cmd),
        .stat_o       (stat),
        .byte_i       (s_tdata),
        .cfg_we_i     (cfg_valid),
        .cfg_data_i   (cfg_data),
        .out_status_o (out_status),
        .out_byte_o   (out_byte),
        .out_len_o    (out_len),
        .out_last_o   (m_tlast)
    );

    // Pack the result fields, lowest first, padded to whole bytes
    assign m_tdata = {3'b000, out_len, out_byte};
    assign m_tuser = out_status;

endmodule
